[hdl/matrix_3x3_inverse_top_macros.svh]
// ----------------------------------------------------------------------------
// matrix_3x3_inverse_top_macros.svh
// assertion macros used by the checker file mi3_checker.sv
// ----------------------------------------------------------------------------
`ifndef MATRIX_3X3_INVERSE_TOP_MACROS_SVH
`define MATRIX_3X3_INVERSE_TOP_MACROS_SVH

// same-cycle implication
`define MI3_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MI3_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/mi3_pkg.sv]
// ----------------------------------------------------------------------------
// mi3_pkg
// constants and cofactor index tables of the 3x3 matrix inverse
// ----------------------------------------------------------------------------
`default_nettype none

package mi3_pkg;

  localparam int INV_WIDTH = 32;
  localparam int DET_WIDTH = 50;
  localparam int OUT_FRAC  = 16;
  localparam int N_ENT     = 9;

  // cofactor k = a[P]*a[Q] - a[R]*a[S], row order of the adjugate
  localparam int CF_P [N_ENT] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int CF_Q [N_ENT] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int CF_R [N_ENT] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int CF_S [N_ENT] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage

`default_nettype wire

[hdl/mi3_in_if.sv]
// ----------------------------------------------------------------------------
// mi3_in_if
// request channel carrying one 3x3 matrix
// ----------------------------------------------------------------------------
`default_nettype none

interface mi3_in_if #(parameter int EW = 16);
  logic valid;
  logic ready;
  logic signed [EW-1:0] a_r0c0;
  logic signed [EW-1:0] a_r0c1;
  logic signed [EW-1:0] a_r0c2;
  logic signed [EW-1:0] a_r1c0;
  logic signed [EW-1:0] a_r1c1;
  logic signed [EW-1:0] a_r1c2;
  logic signed [EW-1:0] a_r2c0;
  logic signed [EW-1:0] a_r2c1;
  logic signed [EW-1:0] a_r2c2;

  modport source (output valid, a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2,
                  a_r2c0, a_r2c1, a_r2c2, input ready);
  modport sink (input valid, a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2,
                a_r2c0, a_r2c1, a_r2c2, output ready);
endinterface

`default_nettype wire

[hdl/mi3_out_if.sv]
// ----------------------------------------------------------------------------
// mi3_out_if
// result channel carrying the inverse, determinant and singular flag
// ----------------------------------------------------------------------------
`default_nettype none

interface mi3_out_if;
  logic valid;
  logic ready;
  logic signed [mi3_pkg::INV_WIDTH-1:0] inv_r0c0;
  logic signed [mi3_pkg::INV_WIDTH-1:0] inv_r0c1;
  logic signed [mi3_pkg::INV_WIDTH-1:0] inv_r0c2;
  logic signed [mi3_pkg::INV_WIDTH-1:0] inv_r1c0;
  logic signed [mi3_pkg::INV_WIDTH-1:0] inv_r1c1;
  logic signed [mi3_pkg::INV_WIDTH-1:0] inv_r1c2;
  logic signed [mi3_pkg::INV_WIDTH-1:0] inv_r2c0;
  logic signed [mi3_pkg::INV_WIDTH-1:0] inv_r2c1;
  logic signed [mi3_pkg::INV_WIDTH-1:0] inv_r2c2;
  logic signed [mi3_pkg::DET_WIDTH-1:0] determinant;
  logic singular;

  modport source (output valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
                  inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, determinant, singular,
                  input ready);
  modport sink (input valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
                inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, determinant, singular,
                output ready);
endinterface

`default_nettype wire

[hdl/matrix_3x3_inverse_top.sv]
// ----------------------------------------------------------------------------
// matrix_3x3_inverse_top
// 3x3 fixed-point inverse by adjugate over determinant, fully pipelined
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  in_if    | sink      | a_r0c0 .. a_r2c2, signed ENTRY_WIDTH
//  out_if   | source    | inv_r0c0 .. inv_r2c2, determinant, singular
//
//  one matrix per cycle while the output is not stalled; five arithmetic
//  stages, one divider setup stage, one stage per quotient bit of the 32-bit
//  divider lanes and one output stage; the quotient bits set the depth
//  synchronous active-low reset clears the stage valid bits only
//  every stage holds while its successor is full and stalled
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_3x3_inverse_top #(
  parameter int ENTRY_WIDTH   = 16,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mi3_in_if.sink    in_if,
  mi3_out_if.source out_if
);

  localparam int EW   = ENTRY_WIDTH;
  localparam int NL   = mi3_pkg::N_ENT;
  localparam int QB   = mi3_pkg::INV_WIDTH;
  localparam int DETW = mi3_pkg::DET_WIDTH;
  localparam int PW   = 2 * EW;
  localparam int CW   = 2 * EW + 1;
  localparam int CMW  = 2 * EW;
  localparam int DPW  = 3 * EW + 1;
  localparam int DW   = 3 * EW + 3;
  localparam int SH   = mi3_pkg::OUT_FRAC + FRACTION_BITS;
  localparam int DVW  = CMW + SH;
  localparam int RW   = DW + QB;
  localparam int DS0  = 5;
  localparam int NS   = QB + 7;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QB-1:0] q;
    logic          ovf;
    logic          neg;
  } lane_t;

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_in;
  logic [NS-1:0] go;

  logic signed [EW-1:0] a [NL];

  // stage 0: products
  logic signed [PW-1:0] pp_r [NL];
  logic signed [PW-1:0] pn_r [NL];
  logic signed [EW-1:0] ac0_r [3];
  // stage 1: cofactors
  logic signed [CW-1:0] cof1_r [NL];
  logic signed [EW-1:0] ac1_r [3];
  // stage 2: determinant partial products
  logic signed [DPW-1:0] dp_r [3];
  logic signed [CW-1:0]  cof2_r [NL];
  // stage 3: determinant, cofactor magnitudes
  logic signed [DW-1:0] det_r;
  logic [CMW-1:0]       cmag_r [NL];
  logic [NL-1:0]        cneg_r;
  // stage 4: determinant magnitude
  logic [DW-1:0]        dmag_r;
  logic [NL-1:0]        neg_r;
  logic                 zero_r;
  logic [DETW-1:0]      det4_r;
  logic [CMW-1:0]       cmag4_r [NL];
  // divider stages
  lane_t          dl_r [QB+1][NL];
  logic [DW-1:0]  dmag_dr [QB+1];
  logic           zero_dr [QB+1];
  logic [DETW-1:0] det_dr [QB+1];
  // output stage
  logic [QB-1:0]   inv_r [NL];
  logic [DETW-1:0] det_out_r;
  logic            sing_r;

  assign a[0] = in_if.a_r0c0;
  assign a[1] = in_if.a_r0c1;
  assign a[2] = in_if.a_r0c2;
  assign a[3] = in_if.a_r1c0;
  assign a[4] = in_if.a_r1c1;
  assign a[5] = in_if.a_r1c2;
  assign a[6] = in_if.a_r2c0;
  assign a[7] = in_if.a_r2c1;
  assign a[8] = in_if.a_r2c2;

  // flow control
  assign v_in = {v_r[NS-2:0], in_if.valid};
  assign go[NS-1] = !v_r[NS-1] || out_if.ready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_go
    assign go[k] = !v_r[k] || go[k+1];
  end
  assign in_if.ready = go[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= (go & v_in) | (~go & v_r);
    end
  end

  always_ff @(posedge clk) begin
    if (go[0]) begin
      for (int l = 0; l < NL; l++) begin
        pp_r[l] <= a[mi3_pkg::CF_P[l]] * a[mi3_pkg::CF_Q[l]];
        pn_r[l] <= a[mi3_pkg::CF_R[l]] * a[mi3_pkg::CF_S[l]];
      end
      ac0_r[0] <= a[0];
      ac0_r[1] <= a[3];
      ac0_r[2] <= a[6];
    end
  end

  always_ff @(posedge clk) begin
    if (go[1]) begin
      for (int l = 0; l < NL; l++) begin
        cof1_r[l] <= CW'(pp_r[l]) - CW'(pn_r[l]);
      end
      ac1_r <= ac0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go[2]) begin
      for (int i = 0; i < 3; i++) begin
        dp_r[i] <= DPW'(ac1_r[i]) * DPW'(cof1_r[i]);
      end
      cof2_r <= cof1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go[3]) begin
      det_r <= DW'(dp_r[0]) + DW'(dp_r[1]) + DW'(dp_r[2]);
      for (int l = 0; l < NL; l++) begin
        cneg_r[l] <= cof2_r[l][CW-1];
        cmag_r[l] <= cof2_r[l][CW-1] ? CMW'(-cof2_r[l]) : CMW'(cof2_r[l]);
      end
    end
  end

  logic signed [DW+DETW-1:0] det_ext;
  assign det_ext = (DW + DETW)'(det_r);

  always_ff @(posedge clk) begin
    if (go[4]) begin
      dmag_r  <= det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
      zero_r  <= (det_r == '0);
      neg_r   <= cneg_r ^ {NL{det_r[DW-1]}};
      det4_r  <= det_ext[DETW-1:0];
      cmag4_r <= cmag_r;
    end
  end

  // divider setup: overflow when the quotient needs more than QB bits
  logic [RW-1:0] dvd [NL];
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      dvd[l] = RW'({cmag4_r[l], {SH{1'b0}}});
    end
  end

  always_ff @(posedge clk) begin
    if (go[DS0]) begin
      for (int l = 0; l < NL; l++) begin
        dl_r[0][l].rem <= dvd[l];
        dl_r[0][l].q   <= '0;
        dl_r[0][l].ovf <= (dvd[l] >= {dmag_r, {QB{1'b0}}});
        dl_r[0][l].neg <= neg_r[l];
      end
      dmag_dr[0] <= dmag_r;
      zero_dr[0] <= zero_r;
      det_dr[0]  <= det4_r;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int BI = QB - 1 - j;
    logic [RW-1:0] dsh;
    assign dsh = RW'(dmag_dr[j]) << BI;

    always_ff @(posedge clk) begin
      if (go[DS0+1+j]) begin
        for (int l = 0; l < NL; l++) begin
          if (dl_r[j][l].rem >= dsh) begin
            dl_r[j+1][l].rem <= dl_r[j][l].rem - dsh;
            dl_r[j+1][l].q   <= dl_r[j][l].q | (QB'(1) << BI);
          end else begin
            dl_r[j+1][l].rem <= dl_r[j][l].rem;
            dl_r[j+1][l].q   <= dl_r[j][l].q;
          end
          dl_r[j+1][l].ovf <= dl_r[j][l].ovf;
          dl_r[j+1][l].neg <= dl_r[j][l].neg;
        end
        dmag_dr[j+1] <= dmag_dr[j];
        zero_dr[j+1] <= zero_dr[j];
        det_dr[j+1]  <= det_dr[j];
      end
    end
  end

  // saturate and apply sign
  logic [QB-1:0] cap  [NL];
  logic [QB-1:0] qsat [NL];
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      cap[l]  = dl_r[QB][l].neg ? {1'b1, {(QB-1){1'b0}}} : {1'b0, {(QB-1){1'b1}}};
      qsat[l] = (dl_r[QB][l].ovf || dl_r[QB][l].q > cap[l]) ? cap[l] : dl_r[QB][l].q;
    end
  end

  always_ff @(posedge clk) begin
    if (go[NS-1]) begin
      for (int l = 0; l < NL; l++) begin
        if (zero_dr[QB]) begin
          inv_r[l] <= '0;
        end else begin
          inv_r[l] <= dl_r[QB][l].neg ? -qsat[l] : qsat[l];
        end
      end
      det_out_r <= det_dr[QB];
      sing_r    <= zero_dr[QB];
    end
  end

  assign out_if.valid       = v_r[NS-1];
  assign out_if.inv_r0c0    = inv_r[0];
  assign out_if.inv_r0c1    = inv_r[1];
  assign out_if.inv_r0c2    = inv_r[2];
  assign out_if.inv_r1c0    = inv_r[3];
  assign out_if.inv_r1c1    = inv_r[4];
  assign out_if.inv_r1c2    = inv_r[5];
  assign out_if.inv_r2c0    = inv_r[6];
  assign out_if.inv_r2c1    = inv_r[7];
  assign out_if.inv_r2c2    = inv_r[8];
  assign out_if.determinant = det_out_r;
  assign out_if.singular    = sing_r;

endmodule

`default_nettype wire

[hdl/mi3_checker.sv]
// ----------------------------------------------------------------------------
// mi3_checker
// port-level checks of the 3x3 matrix inverse result channel
// ----------------------------------------------------------------------------
`default_nettype none

`include "matrix_3x3_inverse_top_macros.svh"

module mi3_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_singular,
  input wire logic [mi3_pkg::DET_WIDTH-1:0] out_det,
  input wire logic [9*mi3_pkg::INV_WIDTH-1:0] out_inv
);

  `MI3_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `MI3_ASSERT_SAME(a_sing, clk, rst_n, out_valid && out_singular, out_det == '0 && out_inv == '0, "singular result not zero")
  `MI3_ASSERT_SAME(a_nonsing, clk, rst_n, out_valid && !out_singular, out_det != '0, "zero determinant not flagged")
  `MI3_ASSERT_NEXT(a_reset, clk, 1'b1, !rst_n, !out_valid, "result valid after reset")

endmodule

bind matrix_3x3_inverse_top mi3_checker u_mi3_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_singular (out_if.singular),
  .out_det      (out_if.determinant),
  .out_inv      ({out_if.inv_r0c0, out_if.inv_r0c1, out_if.inv_r0c2,
                  out_if.inv_r1c0, out_if.inv_r1c1, out_if.inv_r1c2,
                  out_if.inv_r2c0, out_if.inv_r2c1, out_if.inv_r2c2})
);

`default_nettype wire

[sim/mi3_tb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_tb_if
// testbench side of the matrix and inverse channels
// ----------------------------------------------------------------------------
// the block's own interfaces mi3_in_if and mi3_out_if are used directly;
// this file only holds the entry type and result record used by the testbench
// ----------------------------------------------------------------------------
package mi3_tb_pkg;
  typedef logic signed [15:0] entry_t;
  typedef struct {
    logic signed [31:0] inv [9];
    logic signed [49:0] det;
    logic               sing;
  } inverse_t;
endpackage

[sim/matrix_3x3_inverse_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_3x3_inverse_top_tb
// checks the pipelined 3x3 fixed-point inverse against an exact predictor
// ----------------------------------------------------------------------------
// directed extremes, singular and saturating matrices, then random
// well-conditioned, small and full-range matrices, with random idling on
// both channels, a long output stall and a drain pause
// ----------------------------------------------------------------------------
module matrix_3x3_inverse_top_tb;

  localparam int LATENCY = 39;
  localparam int WATCHDOG = 20000;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   idle_cycles;
  bit   hold_out;
  int   hold_cycles;
  mi3_tb_pkg::inverse_t expected_q[$];

  mi3_in_if  #(.EW(16)) in_if ();
  mi3_out_if out_if ();

  matrix_3x3_inverse_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic signed [31:0] divide_sat(logic signed [63:0] cof,
                                                    logic signed [63:0] det);
    logic [127:0] num;
    logic [127:0] dmag;
    logic [127:0] q;
    logic         neg;
    logic [127:0] cap;
    neg  = cof[63] ^ det[63];
    num  = {64'd0, (cof[63] ? -cof : cof)} << 24;
    dmag = {64'd0, (det[63] ? -det : det)};
    q    = num / dmag;
    cap  = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > cap) q = cap;
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic mi3_tb_pkg::inverse_t invert(mi3_tb_pkg::entry_t a[9]);
    mi3_tb_pkg::inverse_t r;
    logic signed [63:0] x[9];
    logic signed [63:0] c[9];
    logic signed [63:0] d;
    for (int k = 0; k < 9; k++) x[k] = 64'(a[k]);
    c[0] = x[4]*x[8] - x[5]*x[7];
    c[1] = x[2]*x[7] - x[1]*x[8];
    c[2] = x[1]*x[5] - x[2]*x[4];
    c[3] = x[5]*x[6] - x[3]*x[8];
    c[4] = x[0]*x[8] - x[2]*x[6];
    c[5] = x[2]*x[3] - x[0]*x[5];
    c[6] = x[3]*x[7] - x[4]*x[6];
    c[7] = x[1]*x[6] - x[0]*x[7];
    c[8] = x[0]*x[4] - x[1]*x[3];
    d = x[0]*c[0] + x[3]*c[1] + x[6]*c[2];
    r.sing = (d == 0);
    r.det  = d[49:0];
    for (int k = 0; k < 9; k++) r.inv[k] = r.sing ? 32'sd0 : divide_sat(c[k], d);
    return r;
  endfunction

  task automatic gap(int bias);
    int n;
    n = ($urandom_range(0, 99) < 90) ? $urandom_range(1, bias) : $urandom_range(5, 40);
    repeat (n) @(posedge clk);
  endtask

  task automatic send_matrix(mi3_tb_pkg::entry_t a[9], bit idle);
    if (idle) begin
      in_if.valid <= 1'b0;
      gap(2);
    end
    in_if.valid  <= 1'b1;
    in_if.a_r0c0 <= a[0]; in_if.a_r0c1 <= a[1]; in_if.a_r0c2 <= a[2];
    in_if.a_r1c0 <= a[3]; in_if.a_r1c1 <= a[4]; in_if.a_r1c2 <= a[5];
    in_if.a_r2c0 <= a[6]; in_if.a_r2c1 <= a[7]; in_if.a_r2c2 <= a[8];
    do @(posedge clk); while (!in_if.ready);
    expected_q.push_back(invert(a));
  endtask

  task automatic send_rows(int e0, int e1, int e2, int e3, int e4, int e5,
                           int e6, int e7, int e8);
    mi3_tb_pkg::entry_t a[9];
    a = '{mi3_tb_pkg::entry_t'(e0), mi3_tb_pkg::entry_t'(e1), mi3_tb_pkg::entry_t'(e2),
          mi3_tb_pkg::entry_t'(e3), mi3_tb_pkg::entry_t'(e4), mi3_tb_pkg::entry_t'(e5),
          mi3_tb_pkg::entry_t'(e6), mi3_tb_pkg::entry_t'(e7), mi3_tb_pkg::entry_t'(e8)};
    send_matrix(a, 1'b0);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    wait (expected_q.size() == 0);
    @(posedge clk);
  endtask

  task automatic test_directed();
    send_rows(256, 0, 0, 0, 256, 0, 0, 0, 256);
    send_rows(-256, 0, 0, 0, 512, 0, 0, 0, -128);
    send_rows(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_rows(256, 512, 768, 512, 1024, 1536, 1, 2, 3);
    send_rows(32767, 0, 0, 0, 32767, 0, 0, 0, 32767);
    send_rows(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768);
    send_rows(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767);
    send_rows(1, 0, 0, 0, 1, 0, 0, 0, 1);
    send_rows(-1, 0, 0, 0, 1, 0, 0, 0, 1);
    send_rows(1, 32767, 0, 0, 1, 32767, 0, 0, 1);
    send_rows(-1, -32768, 0, 0, 1, -32768, 0, 0, -1);
    send_rows(0, 256, 0, 0, 0, 256, 256, 0, 0);
    send_rows(32767, 32767, 32767, -32768, -32768, -32768, 5, 6, 7);
    send_rows(-1, -1, -1, -1, -1, -1, -1, -1, -2);
    send_rows(32767, 32766, 0, 32766, 32765, 0, 0, 0, 1);
    send_rows(-32768, 1, 2, 3, -32768, 4, 5, 6, -32768);
    drain();
  endtask

  function automatic mi3_tb_pkg::entry_t rand_entry(int kind);
    case (kind)
      0:       return mi3_tb_pkg::entry_t'($urandom_range(0, 65535));
      1:       return mi3_tb_pkg::entry_t'($signed($urandom_range(0, 8)) - 4);
      default: return mi3_tb_pkg::entry_t'($signed($urandom_range(0, 2047)) - 1024);
    endcase
  endfunction

  task automatic test_random(int count);
    mi3_tb_pkg::entry_t a[9];
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 3);
      for (int k = 0; k < 9; k++) a[k] = rand_entry(kind);
      if (kind == 3) begin
        a[0] = a[0] + 16'sd8192; a[4] = a[4] + 16'sd8192; a[8] = a[8] - 16'sd8192;
      end
      if ($urandom_range(0, 19) == 0)
        for (int k = 0; k < 3; k++) a[6 + k] = a[3 + k];
      send_matrix(a, $urandom_range(0, 3) == 0);
    end
    drain();
  endtask

  task automatic test_backpressure();
    mi3_tb_pkg::entry_t a[9];
    hold_cycles = 300;
    hold_out    = 1'b1;
    for (int i = 0; i < 80; i++) begin
      for (int k = 0; k < 9; k++) a[k] = rand_entry(2);
      send_matrix(a, 1'b0);
    end
    drain();
  endtask

  // receiver: random stalls, plus a long hold when requested
  initial begin
    out_if.ready = 1'b0;
    hold_out     = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_out) begin
        out_if.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_out = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        gap(3);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    mi3_tb_pkg::inverse_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result det=%0d", $time, out_if.determinant);
        mismatches++;
      end else begin
        e = expected_q.pop_front();
        if (out_if.inv_r0c0 !== e.inv[0] || out_if.inv_r0c1 !== e.inv[1] ||
            out_if.inv_r0c2 !== e.inv[2] || out_if.inv_r1c0 !== e.inv[3] ||
            out_if.inv_r1c1 !== e.inv[4] || out_if.inv_r1c2 !== e.inv[5] ||
            out_if.inv_r2c0 !== e.inv[6] || out_if.inv_r2c1 !== e.inv[7] ||
            out_if.inv_r2c2 !== e.inv[8]) begin
          $display("%0t: inverse expected %0d %0d %0d %0d %0d %0d %0d %0d %0d", $time,
                   e.inv[0], e.inv[1], e.inv[2], e.inv[3], e.inv[4], e.inv[5],
                   e.inv[6], e.inv[7], e.inv[8]);
          $display("%0t: inverse actual   %0d %0d %0d %0d %0d %0d %0d %0d %0d", $time,
                   out_if.inv_r0c0, out_if.inv_r0c1, out_if.inv_r0c2, out_if.inv_r1c0,
                   out_if.inv_r1c1, out_if.inv_r1c2, out_if.inv_r2c0, out_if.inv_r2c1,
                   out_if.inv_r2c2);
          mismatches++;
        end
        if (out_if.determinant !== e.det) begin
          $display("%0t: determinant expected %0d actual %0d", $time, e.det,
                   out_if.determinant);
          mismatches++;
        end
        if (out_if.singular !== e.sing) begin
          $display("%0t: singular expected %0b actual %0b", $time, e.sing, out_if.singular);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    mismatches   = 0;
    idle_cycles  = 0;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.a_r0c0 = '0; in_if.a_r0c1 = '0; in_if.a_r0c2 = '0;
    in_if.a_r1c0 = '0; in_if.a_r1c1 = '0; in_if.a_r1c2 = '0;
    in_if.a_r2c0 = '0; in_if.a_r2c1 = '0; in_if.a_r2c2 = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(1000);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule

[filelist.f]
+incdir+hdl
hdl/mi3_pkg.sv
hdl/mi3_in_if.sv
hdl/mi3_out_if.sv
hdl/matrix_3x3_inverse_top.sv
hdl/mi3_checker.sv
sim/mi3_tb_if.sv
sim/matrix_3x3_inverse_top_tb.sv
